// ----- rtl/core/bsfr_pkg.sv -----
// Shared types and constants of the byte-stuffed frame receiver.
package bsfr_pkg;

   localparam int BUFFER_BYTES = 128;
   localparam int BYTE_W       = 8;
   localparam int INDEX_W      = 7;
   localparam int LENGTH_W     = 8;
   localparam int COUNT_W      = $clog2(BUFFER_BYTES + 1);
   localparam int EVENT_W      = 3;
   localparam int CSR_INDEX_W  = 1;

   localparam logic [COUNT_W-1:0] LAST_SLOT  = COUNT_W'(BUFFER_BYTES - 1);
   localparam logic [COUNT_W-1:0] MIN_FRAME  = COUNT_W'(2);
   localparam logic [BYTE_W-1:0]  STUFF_MASK = BYTE_W'(1 << 5);
   localparam logic [BYTE_W-1:0]  FLAG_RESET = 8'd126;
   localparam logic [BYTE_W-1:0]  ESC_RESET  = 8'd125;

   typedef enum logic [EVENT_W-1:0] {
      EV_NONE     = 3'd0,
      EV_STORED   = 3'd1,
      EV_GOOD     = 3'd2,
      EV_REJECT   = 3'd3,
      EV_OVERFLOW = 3'd4
   } event_type;

   typedef enum logic [2:0] {
      PH_WAIT = 3'b001,
      PH_DATA = 3'b010,
      PH_ESC  = 3'b100
   } phase_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FLAG   = 1'b0,
      CSR_ESCAPE = 1'b1
   } csr_index_type;

   typedef struct packed {
      event_type             event_res;
      logic [BYTE_W-1:0]     data_byte;
      logic [INDEX_W-1:0]    byte_index;
      logic [LENGTH_W-1:0]   frame_length;
   } rsp_payload_type;

endpackage

// ----- rtl/core/bsfr_req_if.sv -----
// Received byte channel: valid/ready handshake with one raw line byte.
interface bsfr_req_if;
   import bsfr_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/core/bsfr_rsp_if.sv -----
// Event channel: valid/ready handshake with one receiver event per transaction.
interface bsfr_rsp_if;
   import bsfr_pkg::*;

   logic                valid;
   logic                ready;
   logic [EVENT_W-1:0]  event_res;
   logic [BYTE_W-1:0]   data_byte;
   logic [INDEX_W-1:0]  byte_index;
   logic [LENGTH_W-1:0] frame_length;

   modport source (output valid, output event_res, output data_byte,
                   output byte_index, output frame_length, input ready);
   modport sink   (input valid, input event_res, input data_byte,
                   input byte_index, input frame_length, output ready);
endinterface

// ----- rtl/core/byte_stuffed_frame_receiver.sv -----
// Byte-stuffed frame receiver: unstuffs a raw byte stream and reports one event per byte.
// Each accepted byte yields exactly one event, presented in the event register the cycle
// after the byte is taken. A new byte is accepted every cycle while the event register is
// empty or being drained in that same cycle, so the sustained rate is one byte per clock;
// while an event waits unaccepted, the input side stalls. The per-byte frame state update
// (phase, byte count, length byte) is a single pass of compare logic between the input
// handshake and the event register. The user must write flag and escape values
// through the csr port only while the receiver is idle; the block itself does no check.
module byte_stuffed_frame_receiver (
   input  logic                          clock,
   input  logic                          reset,
   bsfr_req_if.sink                      req_ch,
   bsfr_rsp_if.source                    rsp_ch,
   input  logic                          csr_wr_en,
   input  bsfr_pkg::csr_index_type       csr_index,
   input  logic [bsfr_pkg::BYTE_W-1:0]   csr_wdata
);
   import bsfr_pkg::*;

   logic [BYTE_W-1:0]   flag_ff;
   logic [BYTE_W-1:0]   escape_ff;
   phase_type           phase_ff, phase_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [BYTE_W-1:0]   length_ff, length_in;
   logic                rsp_valid_ff;
   rsp_payload_type     rsp_ff, rsp_in;
   logic                store_en;
   logic [BYTE_W-1:0]   store_byte;
   logic                req_take;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff   <= FLAG_RESET;
         escape_ff <= ESC_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FLAG:   flag_ff   <= csr_wdata;
            CSR_ESCAPE: escape_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      length_in  = length_ff;
      rsp_in     = '{event_res: EV_NONE, default: '0};
      store_en   = 1'b0;
      store_byte = req_ch.rx_byte;

      unique case (phase_ff)
         PH_DATA: begin
            if (req_ch.rx_byte == escape_ff) begin
               phase_in = PH_ESC;
            end else if (req_ch.rx_byte == flag_ff) begin
               if (length_ff == BYTE_W'(count_ff) && count_ff >= MIN_FRAME) begin
                  phase_in            = PH_WAIT;
                  rsp_in.event_res    = EV_GOOD;
                  rsp_in.frame_length = LENGTH_W'(count_ff);
               end else begin
                  count_in         = '0;
                  rsp_in.event_res = EV_REJECT;
               end
            end else begin
               store_en = 1'b1;
            end
         end
         PH_ESC: begin
            phase_in   = PH_DATA;
            store_en   = 1'b1;
            store_byte = req_ch.rx_byte | STUFF_MASK;
         end
         default: begin
            phase_in = PH_WAIT;
            if (req_ch.rx_byte == flag_ff) begin
               count_in = '0;
               phase_in = PH_DATA;
            end
         end
      endcase

      if (store_en) begin
         if (count_ff == '0) begin
            length_in = store_byte;
         end
         count_in          = count_ff + COUNT_W'(1);
         rsp_in.data_byte  = store_byte;
         rsp_in.byte_index = count_ff[INDEX_W-1:0];
         if (count_ff >= LAST_SLOT) begin
            phase_in         = PH_WAIT;
            rsp_in.event_res = EV_OVERFLOW;
         end else begin
            rsp_in.event_res = EV_STORED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WAIT;
         count_ff     <= '0;
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            phase_ff     <= phase_in;
            count_ff     <= count_in;
            length_ff    <= length_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.event_res    = rsp_ff.event_res;
   assign rsp_ch.data_byte    = rsp_ff.data_byte;
   assign rsp_ch.byte_index   = rsp_ff.byte_index;
   assign rsp_ch.frame_length = rsp_ff.frame_length;

`ifndef NO_ASSERTIONS
   a_take_gives_event: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid_ff)
      else $error("accepted byte produced no event");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(BUFFER_BYTES))
      else $error("byte count past buffer size");

   a_good_min_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.event_res == EV_GOOD |->
         rsp_ff.frame_length >= LENGTH_W'(MIN_FRAME))
      else $error("good frame shorter than minimum");

   a_overflow_abandons: assert property (@(posedge clock) disable iff (reset)
      req_take && rsp_in.event_res == EV_OVERFLOW |=> phase_ff == PH_WAIT)
      else $error("overflow did not abandon frame");

   a_full_only_waiting: assert property (@(posedge clock) disable iff (reset)
      count_ff == COUNT_W'(BUFFER_BYTES) |-> phase_ff == PH_WAIT)
      else $error("full buffer while frame still open");
`endif
endmodule
